/* rtl/core/aabb2_overlap_join_core_macros.svh */
// Assertion macros for the box overlap join core.
// Used by modules that carry checks; needs clk and rst_n in scope.
`ifndef AABB2_OVERLAP_JOIN_CORE_MACROS_SVH
`define AABB2_OVERLAP_JOIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define A2J_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("a2j check failed");
`define A2J_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("a2j sequence check failed");
`else
`define A2J_ASSERT(lbl, prop)
`define A2J_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* rtl/core/aabb2_pkg.sv */
// Shared types and codes for the box overlap join core.
// No dependencies.
package aabb2_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_END   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] KIND_PAIR  = 2'd0;
  localparam logic [1:0] KIND_NOHIT = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_CAP  = 2'd1;

  localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t         op;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] max_x;
    logic [31:0] max_y;
  } item_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] cap;
  } cfg_t;

endpackage

/* rtl/core/aabb2_front.sv */
// Front end: accepts input transfers, decodes the function and drops loads
// into a full table. Depends on aabb2_pkg.
module aabb2_front #(
  parameter int MAX_BOXES = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  input  logic [31:0]     in_min_x,
  input  logic [31:0]     in_min_y,
  input  logic [31:0]     in_max_x,
  input  logic [31:0]     in_max_y,
  input  logic            q_full,
  output logic            q_push,
  output aabb2_pkg::item_t q_item
);
  import aabb2_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             take;
  logic             tbl_full;
  op_t              op;

  assign op       = op_t'(in_func);
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign tbl_full = (fill_r == CNT_W'(MAX_BOXES));
  assign q_push   = take && !(op == OP_LOAD && tbl_full);

  always_comb begin
    q_item.op    = op;
    q_item.min_x = in_min_x;
    q_item.min_y = in_min_y;
    q_item.max_x = in_max_x;
    q_item.max_y = in_max_y;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (take) begin
      case (op)
        OP_LOAD:  if (!tbl_full) fill_nxt = fill_r + CNT_W'(1);
        OP_CLEAR: fill_nxt = '0;
        default:  fill_nxt = fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

/* rtl/core/aabb2_fifo.sv */
// Four-entry item queue between front and back end.
// Depends on aabb2_pkg.
module aabb2_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aabb2_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output aabb2_pkg::item_t head
);
  import aabb2_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            buf_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = (count_r == (PTR_W+1)'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (PTR_W+1)'(1);
        2'b01:   count_r <= count_r - (PTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/core/aabb2_back.sv */
// Back end: box table, query scan, batch counters and result register.
// Depends on aabb2_pkg and aabb2_overlap_join_core_macros.svh.
`include "aabb2_overlap_join_core_macros.svh"
module aabb2_back #(
  parameter int MAX_BOXES   = 32,
  parameter int COORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  aabb2_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  aabb2_pkg::item_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_query_num,
  output logic [4:0]       out_prim_idx,
  output logic             out_last,
  output logic [31:0]      out_pair_count,
  output logic             out_past_capacity,
  output logic             out_status
);
  import aabb2_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int WORD_W = 4 * COORD_WIDTH;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  typedef logic signed [COORD_WIDTH-1:0] crd_t;

  function automatic logic [4:0] prim_of(input logic [CNT_W-1:0] i);
    logic [CNT_W+4:0] t;
    t = {5'b0, i};
    return t[4:0];
  endfunction

  logic [WORD_W-1:0] mem [MAX_BOXES];
  logic [WORD_W-1:0] rdata_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      qc_r, qc_nxt;
  logic [31:0]      pc_r, pc_nxt;
  crd_t             qlx_r, qly_r, qhx_r, qhy_r;
  crd_t             qlx_nxt, qly_nxt, qhx_nxt, qhy_nxt;
  logic [31:0]      qid_r, qid_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [CNT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             held_v_r, held_v_nxt;
  logic [CNT_W-1:0] held_idx_r, held_idx_nxt;
  logic [31:0]      held_cnt_r, held_cnt_nxt;
  logic             held_past_r, held_past_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [31:0] out_qid_r, out_qid_nxt;
  logic [4:0]  out_prim_r, out_prim_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] out_cnt_r, out_cnt_nxt;
  logic        out_past_r, out_past_nxt;
  logic        out_stat_r, out_stat_nxt;

  logic        out_busy, issue, touch, hit, adv, rd_en, scan_done, wr_en;
  logic [31:0] pc_inc;
  crd_t        blx, bly, bhx, bhy;

  assign blx = rdata_r[COORD_WIDTH-1:0];
  assign bly = rdata_r[2*COORD_WIDTH-1:COORD_WIDTH];
  assign bhx = rdata_r[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign bhy = rdata_r[4*COORD_WIDTH-1:3*COORD_WIDTH];

  assign out_busy  = out_valid_r && !out_ready;
  assign q_pop     = q_valid && (state_r == S_IDLE) && (q_head.op != OP_END || !out_busy);
  assign wr_en     = q_pop && (q_head.op == OP_LOAD) && (cnt_r < CNT_W'(MAX_BOXES));
  assign issue     = (state_r == S_SCAN) && (idx_r < cnt_r);
  assign touch     = (qlx_r <= bhx) && (qhx_r >= blx) && (qly_r <= bhy) && (qhy_r >= bly);
  assign hit       = cmp_v_r && touch;
  assign adv       = !(hit && held_v_r && out_busy);
  assign rd_en     = issue && adv;
  assign scan_done = (state_r == S_SCAN) && !issue && !cmp_v_r;
  assign pc_inc    = (pc_r == CNT_SAT) ? pc_r : pc_r + 32'd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= {q_head.max_y[COORD_WIDTH-1:0], q_head.max_x[COORD_WIDTH-1:0],
                                q_head.min_y[COORD_WIDTH-1:0], q_head.min_x[COORD_WIDTH-1:0]};
    end
    if (rd_en) rdata_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    qc_nxt        = qc_r;
    pc_nxt        = pc_r;
    qlx_nxt       = qlx_r;
    qly_nxt       = qly_r;
    qhx_nxt       = qhx_r;
    qhy_nxt       = qhy_r;
    qid_nxt       = qid_r;
    idx_nxt       = idx_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    held_v_nxt    = held_v_r;
    held_idx_nxt  = held_idx_r;
    held_cnt_nxt  = held_cnt_r;
    held_past_nxt = held_past_r;
    out_valid_nxt = out_busy;
    out_kind_nxt  = out_kind_r;
    out_qid_nxt   = out_qid_r;
    out_prim_nxt  = out_prim_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    out_past_nxt  = out_past_r;
    out_stat_nxt  = out_stat_r;

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_head.op)
            OP_LOAD: begin
              if (wr_en) cnt_nxt = cnt_r + CNT_W'(1);
            end
            OP_QUERY: begin
              qlx_nxt    = q_head.min_x[COORD_WIDTH-1:0];
              qly_nxt    = q_head.min_y[COORD_WIDTH-1:0];
              qhx_nxt    = q_head.max_x[COORD_WIDTH-1:0];
              qhy_nxt    = q_head.max_y[COORD_WIDTH-1:0];
              qid_nxt    = qc_r;
              idx_nxt    = '0;
              cmp_v_nxt  = 1'b0;
              held_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            OP_END: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_SUM;
              out_qid_nxt   = qc_r;
              out_prim_nxt  = '0;
              out_last_nxt  = 1'b1;
              out_cnt_nxt   = pc_r;
              out_past_nxt  = 1'b0;
              out_stat_nxt  = cfg.mode && (pc_r > cfg.cap);
              qc_nxt        = '0;
              pc_nxt        = '0;
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
              qc_nxt  = '0;
              pc_nxt  = '0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (adv) begin
          cmp_v_nxt   = issue;
          cmp_idx_nxt = idx_r;
          if (issue) idx_nxt = idx_r + CNT_W'(1);
          if (hit) begin
            pc_nxt        = pc_inc;
            held_v_nxt    = 1'b1;
            held_idx_nxt  = cmp_idx_r;
            held_cnt_nxt  = pc_inc;
            held_past_nxt = cfg.mode && (pc_inc > cfg.cap);
            if (held_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_PAIR;
              out_qid_nxt   = qid_r;
              out_prim_nxt  = prim_of(held_idx_r);
              out_last_nxt  = 1'b0;
              out_cnt_nxt   = held_cnt_r;
              out_past_nxt  = held_past_r;
              out_stat_nxt  = 1'b0;
            end
          end
        end
        if (scan_done && !out_busy) begin
          out_valid_nxt = 1'b1;
          out_qid_nxt   = qid_r;
          out_last_nxt  = 1'b1;
          out_stat_nxt  = 1'b0;
          if (held_v_r) begin
            out_kind_nxt = KIND_PAIR;
            out_prim_nxt = prim_of(held_idx_r);
            out_cnt_nxt  = held_cnt_r;
            out_past_nxt = held_past_r;
          end else begin
            out_kind_nxt = KIND_NOHIT;
            out_prim_nxt = '0;
            out_cnt_nxt  = pc_r;
            out_past_nxt = 1'b0;
          end
          qc_nxt     = (qc_r == CNT_SAT) ? qc_r : qc_r + 32'd1;
          held_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      qc_r        <= '0;
      pc_r        <= '0;
      cmp_v_r     <= 1'b0;
      held_v_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      qc_r        <= qc_nxt;
      pc_r        <= pc_nxt;
      cmp_v_r     <= cmp_v_nxt;
      held_v_r    <= held_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qlx_r       <= qlx_nxt;
    qly_r       <= qly_nxt;
    qhx_r       <= qhx_nxt;
    qhy_r       <= qhy_nxt;
    qid_r       <= qid_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    held_idx_r  <= held_idx_nxt;
    held_cnt_r  <= held_cnt_nxt;
    held_past_r <= held_past_nxt;
    out_kind_r  <= out_kind_nxt;
    out_qid_r   <= out_qid_nxt;
    out_prim_r  <= out_prim_nxt;
    out_last_r  <= out_last_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_past_r  <= out_past_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_query_num     = out_qid_r;
  assign out_prim_idx      = out_prim_r;
  assign out_last          = out_last_r;
  assign out_pair_count    = out_cnt_r;
  assign out_past_capacity = out_past_r;
  assign out_status        = out_stat_r;

  `A2J_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_BOXES))
  `A2J_ASSERT(a_held_in_scan, held_v_r |-> state_r == S_SCAN)
  `A2J_ASSERT(a_idx_bound, state_r == S_SCAN |-> idx_r <= cnt_r)
  `A2J_ASSERT_NEXT(a_done_emits, scan_done && !out_busy, out_valid_r && out_last_r)

endmodule

/* rtl/core/aabb2_overlap_join_core.sv */
//  channel | direction | transfer carries
//  in_     | input     | func, box corners min_x min_y max_x max_y
//  out_    | output    | kind, query_num, prim_idx, last, pair_count, past_capacity, status
//  cfg_    | input     | index (0 caller_buffer_mode, 1 pair_capacity), data
// Loads, clears and batch ends are taken straight from the queue head; a query scans the
// table, read one entry per cycle while no result stall holds the scan.
// A four-entry queue lets input transfers continue while a query scans.
// Result stalls hold the scan when a further hit or the final result needs the output
// register; a batch end waits for it as well.
// Reset is synchronous, active low; the box table is not cleared.
module aabb2_overlap_join_core #(
  parameter int MAX_BOXES   = 32,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_min_x,
  input  logic [31:0] in_min_y,
  input  logic [31:0] in_max_x,
  input  logic [31:0] in_max_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_query_num,
  output logic [4:0]  out_prim_idx,
  output logic        out_last,
  output logic [31:0] out_pair_count,
  output logic        out_past_capacity,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import aabb2_pkg::*;

  cfg_t  cfg_r;
  item_t push_item, head;
  logic  q_full, q_push, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: cfg_r.mode <= cfg_data[0];
        REG_CAP:  cfg_r.cap  <= cfg_data;
        default:  cfg_r      <= cfg_r;
      endcase
    end
  end

  aabb2_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_min_x (in_min_x),
    .in_min_y (in_min_y),
    .in_max_x (in_max_x),
    .in_max_y (in_max_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  aabb2_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head)
  );

  aabb2_back #(.MAX_BOXES(MAX_BOXES), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_head            (head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_query_num     (out_query_num),
    .out_prim_idx      (out_prim_idx),
    .out_last          (out_last),
    .out_pair_count    (out_pair_count),
    .out_past_capacity (out_past_capacity),
    .out_status        (out_status)
  );

endmodule

/* tb/sv/aabb2_overlap_join_check.sv */
`timescale 1ns / 100ps
// Transfer checker for aabb2_overlap_join_core: keeps its own copy of the box table,
// counters and registers, predicts results per input transfer and compares them in order.
// Depends on aabb2_pkg for op, kind and register codes.
module aabb2_overlap_join_check #(
  parameter int MAX_BOXES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_min_x,
  input  logic [31:0] in_min_y,
  input  logic [31:0] in_max_x,
  input  logic [31:0] in_max_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_query_num,
  input  logic [4:0]  out_prim_idx,
  input  logic        out_last,
  input  logic [31:0] out_pair_count,
  input  logic        out_past_capacity,
  input  logic        out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          outstanding,
  output int          items_seen,
  output int          results_seen
);
  import aabb2_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] qid;
    logic [4:0]  prim;
    logic        last;
    logic [31:0] count;
    logic        past;
    logic        status;
  } join_result_t;

  logic signed [31:0] tbl_lx [MAX_BOXES];
  logic signed [31:0] tbl_ly [MAX_BOXES];
  logic signed [31:0] tbl_hx [MAX_BOXES];
  logic signed [31:0] tbl_hy [MAX_BOXES];
  int                 boxes;
  logic [31:0]        queries;
  logic [31:0]        pairs;
  logic               mode;
  logic [31:0]        cap;
  join_result_t       expected_results [$];
  int                 errors;
  int                 n_items;
  int                 n_results;

  function automatic join_result_t make_result(input logic [1:0] kind, input logic [31:0] qid,
                                               input logic [4:0] prim, input logic last,
                                               input logic [31:0] count, input logic past,
                                               input logic status);
    join_result_t r;
    r.kind   = kind;
    r.qid    = qid;
    r.prim   = prim;
    r.last   = last;
    r.count  = count;
    r.past   = past;
    r.status = status;
    return r;
  endfunction

  function automatic string fmt(input join_result_t r);
    return $sformatf("kind %0d qid %0d prim %0d last %0b count %0d past %0b status %0b",
                     r.kind, r.qid, r.prim, r.last, r.count, r.past, r.status);
  endfunction

  function automatic void enqueue(input join_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic join_step(input logic [1:0] func,
                           input logic signed [31:0] lx, input logic signed [31:0] ly,
                           input logic signed [31:0] hx, input logic signed [31:0] hy);
    join_result_t r;
    int           hits;
    int           i;
    case (func)
      OP_LOAD: begin
        if (boxes < MAX_BOXES) begin
          tbl_lx[boxes] = lx;
          tbl_ly[boxes] = ly;
          tbl_hx[boxes] = hx;
          tbl_hy[boxes] = hy;
          boxes++;
        end
      end
      OP_QUERY: begin
        hits = 0;
        for (i = 0; i < boxes; i++) begin
          if (lx <= tbl_hx[i] && hx >= tbl_lx[i] && ly <= tbl_hy[i] && hy >= tbl_ly[i]) begin
            if (pairs != CNT_SAT) pairs = pairs + 32'd1;
            enqueue(make_result(KIND_PAIR, queries, 5'(i), 1'b0, pairs,
                                mode && (pairs > cap), 1'b0));
            hits++;
          end
        end
        if (hits == 0) begin
          enqueue(make_result(KIND_NOHIT, queries, 5'd0, 1'b1, pairs, 1'b0, 1'b0));
        end else begin
          r = expected_results.pop_back();
          r.last = 1'b1;
          enqueue(r);
        end
        if (queries != CNT_SAT) queries = queries + 32'd1;
      end
      OP_END: begin
        enqueue(make_result(KIND_SUM, queries, 5'd0, 1'b1, pairs, 1'b0,
                            mode && (pairs > cap)));
        queries = '0;
        pairs   = '0;
      end
      default: begin
        boxes   = 0;
        queries = '0;
        pairs   = '0;
      end
    endcase
  endtask

  task automatic check_result();
    join_result_t want;
    join_result_t got;
    got = make_result(out_kind, out_query_num, out_prim_idx, out_last, out_pair_count,
                      out_past_capacity, out_status);
    n_results++;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t: unexpected result transfer: %s", $time, fmt(got));
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      boxes     = 0;
      queries   = '0;
      pairs     = '0;
      mode      = 1'b0;
      cap       = '0;
      errors    = 0;
      n_items   = 0;
      n_results = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) mode = cfg_data[0];
        else if (cfg_index == REG_CAP) cap = cfg_data;
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        join_step(in_func, in_min_x, in_min_y, in_max_x, in_max_y);
        n_items++;
      end
    end
    mismatch_count <= errors;
    outstanding    <= expected_results.size();
    items_seen     <= n_items;
    results_seen   <= n_results;
  end

endmodule

/* tb/sv/aabb2_overlap_join_core_tb.sv */
`timescale 1ns / 100ps
// Top of the aabb2_overlap_join_core testbench: clock, reset, directed and random stimulus,
// random stalls on the result channel and the verdict. Needs aabb2_pkg and aabb2_overlap_join_check.
module aabb2_overlap_join_core_tb;
  import aabb2_pkg::*;

  localparam int          TABLE_DEPTH = 32;
  localparam logic [31:0] UNIT        = 32'h0001_0000;
  localparam logic [31:0] NEG_UNIT    = 32'hFFFF_0000;
  localparam logic [31:0] CRD_MIN     = 32'h8000_0000;
  localparam logic [31:0] CRD_MAX     = 32'h7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [31:0] in_min_x;
  logic [31:0] in_min_y;
  logic [31:0] in_max_x;
  logic [31:0] in_max_y;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  out_kind;
  logic [31:0] out_query_num;
  logic [4:0]  out_prim_idx;
  logic        out_last;
  logic [31:0] out_pair_count;
  logic        out_past_capacity;
  logic        out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int   mismatch_count;
  int   outstanding;
  int   items_seen;
  int   results_seen;
  int   stall = 0;
  logic steady;
  int   sent_items;
  int   settings_used;

  aabb2_overlap_join_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_min_x          (in_min_x),
    .in_min_y          (in_min_y),
    .in_max_x          (in_max_x),
    .in_max_y          (in_max_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_query_num     (out_query_num),
    .out_prim_idx      (out_prim_idx),
    .out_last          (out_last),
    .out_pair_count    (out_pair_count),
    .out_past_capacity (out_past_capacity),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  aabb2_overlap_join_check #(.MAX_BOXES(TABLE_DEPTH)) check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_min_x          (in_min_x),
    .in_min_y          (in_min_y),
    .in_max_x          (in_max_x),
    .in_max_y          (in_max_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_query_num     (out_query_num),
    .out_prim_idx      (out_prim_idx),
    .out_last          (out_last),
    .out_pair_count    (out_pair_count),
    .out_past_capacity (out_past_capacity),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding),
    .items_seen        (items_seen),
    .results_seen      (results_seen)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall > 0) begin
      stall     <= stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25) stall <= idle_len();
    end
  end

  task automatic send(input logic [1:0] f, input logic [31:0] x0, input logic [31:0] y0,
                      input logic [31:0] x1, input logic [31:0] y1);
    int gap;
    in_valid <= 1'b1;
    in_func  <= f;
    in_min_x <= x0;
    in_min_y <= y0;
    in_max_x <= x1;
    in_max_y <= y1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every expected result, then leave room for trailing loads and clears
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic apply_setting(input logic m, input logic [31:0] c);
    logic [31:0] junk;
    junk = $urandom;
    settle();
    write_reg(REG_MODE, {junk[31:1], m});
    write_reg(REG_CAP, c);
    settings_used++;
  endtask

  task automatic near_box(input logic [31:0] bx, input logic [31:0] by, input logic [31:0] span,
                          output logic [31:0] x0, output logic [31:0] y0,
                          output logic [31:0] x1, output logic [31:0] y1);
    logic [31:0] t;
    x0 = bx + $urandom_range(0, span);
    x1 = x0 + $urandom_range(0, span >> 2);
    y0 = by + $urandom_range(0, span);
    y1 = y0 + $urandom_range(0, span >> 2);
    if ($urandom_range(0, 19) == 0) begin
      t  = x0;
      x0 = x1;
      x1 = t;
    end
  endtask

  task automatic run_batch(input int idx);
    int          len;
    int          nload;
    int          r;
    int          k;
    logic        m;
    logic [31:0] c;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] span;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
    case (idx)
      0: begin
        m = 1'b1;
        c = 32'd0;
      end
      1: begin
        m = 1'b1;
        c = CNT_SAT;
      end
      default: begin
        m = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 4);
        case (r)
          0: c = 32'd0;
          1: c = CNT_SAT;
          2: c = $urandom_range(0, 16);
          3: c = $urandom_range(0, 64);
          default: c = $urandom;
        endcase
      end
    endcase
    apply_setting(m, c);
    steady <= ($urandom_range(0, 3) == 0);
    bx   = $urandom;
    by   = $urandom;
    span = 32'd1 << $urandom_range(8, 22);
    if (idx == 0 || $urandom_range(0, 3) == 0)
      send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    if (idx == 0) nload = TABLE_DEPTH + 3;
    else if ($urandom_range(0, 7) == 0) nload = $urandom_range(28, 36);
    else nload = $urandom_range(1, 12);
    for (k = 0; k < nload; k++) begin
      near_box(bx, by, span, a0, a1, a2, a3);
      send(OP_LOAD, a0, a1, a2, a3);
    end
    len = $urandom_range(6, 24);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        near_box(bx, by, span << $urandom_range(0, 1), a0, a1, a2, a3);
        send(OP_QUERY, a0, a1, a2, a3);
      end else if (r < 78) begin
        near_box(bx, by, span, a0, a1, a2, a3);
        send(OP_LOAD, a0, a1, a2, a3);
      end else if (r < 88) begin
        send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end else if (r < 94) begin
        send(OP_QUERY, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send(OP_END, $urandom, $urandom, $urandom, $urandom);
      end
    end
    send(OP_END, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int target;
    int batch_no;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_func   <= OP_LOAD;
    in_min_x  <= '0;
    in_min_y  <= '0;
    in_max_x  <= '0;
    in_max_y  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    steady    <= 1'b0;
    sent_items    = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_setting(1'b1, 32'd2);
    send(OP_QUERY, 32'd0, 32'd0, UNIT, UNIT);
    send(OP_END, 32'd0, 32'd0, 32'd0, 32'd0);
    send(OP_LOAD, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX);
    send(OP_LOAD, 32'd0, 32'd0, 32'd0, 32'd0);
    send(OP_LOAD, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX);
    send(OP_LOAD, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN);
    send(OP_LOAD, 32'd0, 32'd0, UNIT, UNIT);
    // inverted box, min above max
    send(OP_LOAD, UNIT, UNIT, NEG_UNIT, NEG_UNIT);
    send(OP_QUERY, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX);
    // shares only a corner with the unit box
    send(OP_QUERY, UNIT, UNIT, UNIT << 1, UNIT << 1);
    send(OP_QUERY, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX);
    send(OP_QUERY, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN);
    send(OP_QUERY, UNIT, UNIT, 32'd0, 32'd0);
    send(OP_QUERY, 32'h4000_0000, 32'h4000_0000, 32'h4000_0001, 32'h4000_0001);
    send(OP_END, 32'd0, 32'd0, 32'd0, 32'd0);
    send(OP_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
    send(OP_QUERY, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX);
    send(OP_LOAD, 32'd0, 32'd0, UNIT, UNIT);
    send(OP_QUERY, UNIT << 1, UNIT << 1, UNIT << 2, UNIT << 2);
    send(OP_END, 32'd0, 32'd0, 32'd0, 32'd0);

    target   = 200;
    batch_no = 0;
    while (sent_items < target) begin
      run_batch(batch_no);
      batch_no++;
    end
    settle();

    $display("Covered %0d input transfers and %0d result transfers in %0d batches,",
             items_seen, results_seen, batch_no);
    $display("across %0d register settings, with %0d mismatches.", settings_used,
             mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
